// ===== rtl/scoped_symbol_stack_table_macros.svh =====
// Assertion macros shared by the checker files of the scoped symbol stack table.
// Depends on nothing; each file that asserts includes it by bare name.
`ifndef SCOPED_SYMBOL_STACK_TABLE_MACROS_SVH
`define SCOPED_SYMBOL_STACK_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define SST_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sst assertion failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define SST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sst assertion failed");

`endif

// ===== rtl/sst_pkg.sv =====
// Package for the scoped symbol stack table: sizes, codes, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
package sst_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned KEY_BITS   = 16;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned PTR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_GET  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_PUSH = 2'd2,
    CMD_POP  = 2'd3
  } sst_cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } sst_status_e;

  // What goes into the result register.
  typedef enum logic [2:0] {
    RES_WDATA,
    RES_RDVAL,
    RES_NOTFOUND,
    RES_EMPTY,
    RES_FULL
  } sst_res_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_GET_HIT,
    S_SET_HIT,
    S_PUSH,
    S_POP,
    S_NOTFOUND,
    S_FULL,
    S_EMPTY
  } sst_state_e;

  typedef struct packed {
    logic     load_in;
    logic     scan_start;
    logic     scan_step;
    logic     rd_top;
    logic     wr_push;
    logic     wr_hit;
    logic     pop_dec;
    logic     res_load;
    sst_res_e res_sel;
  } sst_ctl_t;

  typedef struct packed {
    sst_cmd_e cmd;
    logic     empty;
    logic     full;
    logic     hit;
    logic     miss;
  } sst_sts_t;

endpackage

// ===== rtl/sst_dp.sv =====
// Datapath of the scoped symbol stack table: key/value memories, fill count,
// scan counter, key compare and result register. Depends on sst_pkg.
module sst_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sst_pkg::sst_ctl_t                 ctl_i,
  output sst_pkg::sst_sts_t                 sts_o,
  input  logic [1:0]                        cmd_i,
  input  logic [sst_pkg::KEY_BITS-1:0]      key_i,
  input  logic [sst_pkg::VALUE_BITS-1:0]    data_in_i,
  output logic [sst_pkg::VALUE_BITS-1:0]    data_out_o,
  output logic [1:0]                        status_o
);
  import sst_pkg::*;

  logic [KEY_BITS-1:0]   key_mem [DEPTH];
  logic [VALUE_BITS-1:0] val_mem [DEPTH];

  sst_cmd_e              cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [CNT_W-1:0]      fill_q, fill_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [PTR_W-1:0]      rd_idx_q;
  logic [KEY_BITS-1:0]   rd_key_q;
  logic [VALUE_BITS-1:0] rd_val_q;

  logic [VALUE_BITS-1:0] dout_q, dout_d;
  sst_status_e           status_q, status_d;

  logic                  hit;
  logic                  rd_en;
  logic [PTR_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      scan_m1, fill_m1;
  logic                  wr_en;
  logic [PTR_W-1:0]      wr_addr;

  assign hit     = rd_pend_q && (rd_key_q == key_q);
  assign scan_m1 = scan_q - CNT_W'(1);
  assign fill_m1 = fill_q - CNT_W'(1);

  assign rd_en   = ctl_i.rd_top || (ctl_i.scan_step && !hit && (scan_q != '0));
  assign rd_addr = ctl_i.rd_top ? fill_m1[PTR_W-1:0] : scan_m1[PTR_W-1:0];
  assign wr_en   = ctl_i.wr_push || ctl_i.wr_hit;
  assign wr_addr = ctl_i.wr_hit ? rd_idx_q : fill_q[PTR_W-1:0];

  assign sts_o.cmd   = cmd_q;
  assign sts_o.empty = (fill_q == '0);
  assign sts_o.full  = (fill_q == CNT_W'(DEPTH));
  assign sts_o.hit   = hit;
  assign sts_o.miss  = (scan_q == '0) && !hit;

  // Latched command word
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q <= sst_cmd_e'(cmd_i);
      key_q <= key_i;
      val_q <= data_in_i;
    end
  end

  // Storage, one write and one read port each; read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= key_q;
      val_mem[wr_addr] <= val_q;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_val_q <= val_mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  always_comb begin
    fill_d    = fill_q;
    scan_d    = scan_q;
    rd_pend_d = rd_pend_q;
    if (ctl_i.wr_push) begin
      fill_d = fill_q + CNT_W'(1);
    end else if (ctl_i.pop_dec) begin
      fill_d = fill_m1;
    end
    if (ctl_i.scan_start) begin
      scan_d    = fill_q;
      rd_pend_d = 1'b0;
    end else if (ctl_i.scan_step) begin
      rd_pend_d = rd_en;
      if (rd_en) begin
        scan_d = scan_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      scan_q    <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      scan_q    <= scan_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_comb begin
    dout_d   = '0;
    status_d = ST_OK;
    unique case (ctl_i.res_sel)
      RES_WDATA:    dout_d = val_q;
      RES_RDVAL:    dout_d = rd_val_q;
      RES_NOTFOUND: status_d = ST_NOT_FOUND;
      RES_EMPTY:    status_d = ST_EMPTY;
      RES_FULL:     status_d = ST_FULL;
      default:      status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.res_load) begin
      dout_q   <= dout_d;
      status_q <= status_d;
    end
  end

  assign data_out_o = dout_q;
  assign status_o   = status_q;

endmodule

// ===== rtl/sst_ctrl.sv =====
// Controller of the scoped symbol stack table: operation sequencing FSM and
// the input/output word handshakes. Depends on sst_pkg.
module sst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  sst_pkg::sst_sts_t sts_i,
  output sst_pkg::sst_ctl_t ctl_o
);
  import sst_pkg::*;

  sst_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts_i.cmd)
          CMD_GET:  state_d = sts_i.empty ? S_NOTFOUND : S_SCAN;
          CMD_SET:  state_d = sts_i.empty ? S_PUSH : S_SCAN;
          CMD_PUSH: state_d = sts_i.full ? S_FULL : S_PUSH;
          CMD_POP:  state_d = sts_i.empty ? S_EMPTY : S_POP;
          default:  state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        priority if (sts_i.hit) begin
          state_d = (sts_i.cmd == CMD_GET) ? S_GET_HIT : S_SET_HIT;
        end else if (sts_i.miss) begin
          if (sts_i.cmd == CMD_GET) state_d = S_NOTFOUND;
          else state_d = sts_i.full ? S_FULL : S_PUSH;
        end
      end
      S_GET_HIT, S_SET_HIT, S_PUSH, S_POP, S_NOTFOUND, S_FULL, S_EMPTY: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        ctl_o.load_in = in_valid_i;
      end
      S_DECODE: begin
        ctl_o.scan_start = ((sts_i.cmd == CMD_GET) || (sts_i.cmd == CMD_SET)) && !sts_i.empty;
        ctl_o.rd_top     = (sts_i.cmd == CMD_POP) && !sts_i.empty;
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
      end
      S_GET_HIT: begin
        ctl_o.res_load = out_free;
        ctl_o.res_sel  = RES_RDVAL;
      end
      S_SET_HIT: begin
        ctl_o.res_load = out_free;
        ctl_o.wr_hit   = out_free;
        ctl_o.res_sel  = RES_WDATA;
      end
      S_PUSH: begin
        ctl_o.res_load = out_free;
        ctl_o.wr_push  = out_free;
        ctl_o.res_sel  = RES_WDATA;
      end
      S_POP: begin
        ctl_o.res_load = out_free;
        ctl_o.pop_dec  = out_free;
        ctl_o.res_sel  = RES_RDVAL;
      end
      S_NOTFOUND: begin
        ctl_o.res_load = out_free;
        ctl_o.res_sel  = RES_NOTFOUND;
      end
      S_FULL: begin
        ctl_o.res_load = out_free;
        ctl_o.res_sel  = RES_FULL;
      end
      S_EMPTY: begin
        ctl_o.res_load = out_free;
        ctl_o.res_sel  = RES_EMPTY;
      end
      default: begin
        ctl_o = '0;
      end
    endcase
  end

  assign out_valid_d = ctl_o.res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/scoped_symbol_stack_table.sv =====
// Scoped symbol stack table: a stack of key/value words searched newest
// first, with get, set, push and pop. One word in gives exactly one word out.
// Get and set scan the stack from the top down with one key compare per
// cycle against a single read port of the key memory. Push, pop and
// the errors found at decode, such as get or pop on an empty stack or
// push on a full one, skip the scan and go to a finish state. Items
// are handled one at a time; the input is stalled while one is in work. The
// output is a register of its own, so a new word is taken while a result is
// still stalled on the output, and only the finished next result waits for
// it. data_out is zero on every error status. Stored entries above the fill
// count are never read, so the memories need no clearing after reset.
// Depends on sst_pkg, sst_ctrl and sst_dp.
module scoped_symbol_stack_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     cmd_i,
  input  logic [sst_pkg::KEY_BITS-1:0]   key_i,
  input  logic [sst_pkg::VALUE_BITS-1:0] data_in_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sst_pkg::VALUE_BITS-1:0] data_out_o,
  output logic [1:0]                     status_o
);
  import sst_pkg::*;

  sst_ctl_t ctl;
  sst_sts_t sts;

  // Sequencer: decode, scan, then a finish state that commits the write
  // and the result together once the output register is free.
  sst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Storage, fill count, scan pointer and result register.
  sst_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .sts_o      (sts),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .data_in_i  (data_in_i),
    .data_out_o (data_out_o),
    .status_o   (status_o)
  );

endmodule

// ===== rtl/sst_chk.sv =====
// Port-level checker for the scoped symbol stack table, bound to the top.
// Depends on sst_pkg and scoped_symbol_stack_table_macros.svh.
`include "scoped_symbol_stack_table_macros.svh"

module sst_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [sst_pkg::VALUE_BITS-1:0] data_out_o,
  input logic [1:0]                     status_o
);
  import sst_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign pend_d  = pend_q + {1'b0, in_acc} - {1'b0, out_acc};

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `SST_ASSERT_NOW(a_err_zero, out_valid_o && (status_o != ST_OK), data_out_o == '0)
  `SST_ASSERT_NOW(a_no_orphan_out, out_valid_o, pend_q != 2'd0)
  `SST_ASSERT_NOW(a_two_deep_stall, pend_q == 2'd2, in_stall_o)
  `SST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(data_out_o) && $stable(status_o))

endmodule

bind scoped_symbol_stack_table sst_chk u_sst_chk (.*);

// ===== tb/symbol_table_checker.sv =====
// Checker for the scoped symbol stack table: watches both word channels, keeps
// its own copy of the key/value stack and compares every result word in order.
// Depends on sst_pkg for sizes and the command and status codes.
module symbol_table_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [1:0]                     cmd_i,
  input  logic [sst_pkg::KEY_BITS-1:0]   key_i,
  input  logic [sst_pkg::VALUE_BITS-1:0] data_in_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [sst_pkg::VALUE_BITS-1:0] data_out_i,
  input  logic [1:0]                     status_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    owed_count_o,
  output int unsigned                    words_checked_o,
  output int unsigned                    ok_count_o,
  output int unsigned                    missing_count_o,
  output int unsigned                    empty_count_o,
  output int unsigned                    full_count_o,
  output int unsigned                    peak_fill_o
);
  import sst_pkg::*;

  typedef struct packed {
    logic [VALUE_BITS-1:0] data;
    sst_status_e           status;
  } sym_result_t;

  // shadow of the stack; entries at or above stack_fill are never read
  logic [KEY_BITS-1:0]   shadow_keys   [DEPTH];
  logic [VALUE_BITS-1:0] shadow_values [DEPTH];
  int                    stack_fill = 0;

  sym_result_t owed_results [$];
  sym_result_t want;

  initial begin
    fail_count_o    = 0;
    owed_count_o    = 0;
    words_checked_o = 0;
    ok_count_o      = 0;
    missing_count_o = 0;
    empty_count_o   = 0;
    full_count_o    = 0;
    peak_fill_o     = 0;
  end

  // Applies one command to the shadow stack and returns the word it owes.
  function automatic sym_result_t resolve_symbol_op(input sst_cmd_e op,
                                                   input logic [KEY_BITS-1:0] k,
                                                   input logic [VALUE_BITS-1:0] v);
    sym_result_t r;
    int          hit;
    r.data   = '0;
    r.status = ST_OK;
    hit      = -1;
    // newest-first search
    if (op == CMD_GET || op == CMD_SET) begin
      for (int i = stack_fill - 1; i >= 0; i--) begin
        if (hit < 0 && shadow_keys[i] == k) hit = i;
      end
    end
    case (op)
      CMD_GET: begin
        if (hit >= 0) r.data = shadow_values[hit];
        else r.status = ST_NOT_FOUND;
      end
      CMD_SET: begin
        if (hit >= 0) begin
          shadow_values[hit] = v;
          r.data = v;
        end else if (stack_fill < int'(DEPTH)) begin
          shadow_keys[stack_fill]   = k;
          shadow_values[stack_fill] = v;
          stack_fill++;
          r.data = v;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_PUSH: begin
        if (stack_fill < int'(DEPTH)) begin
          shadow_keys[stack_fill]   = k;
          shadow_values[stack_fill] = v;
          stack_fill++;
          r.data = v;
        end else begin
          r.status = ST_FULL;
        end
      end
      default: begin
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          stack_fill--;
          r.data = shadow_values[stack_fill];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_fill = 0;
      owed_results.delete();
      owed_count_o = 0;
    end else begin
      // result side first; a word can never come out on the edge it went in
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $error("result word with nothing owed: data_out %h status %0d",
                 data_out_i, status_i);
          fail_count_o++;
        end else begin
          want = owed_results.pop_front();
          words_checked_o++;
          if (data_out_i !== want.data) begin
            $error("data_out mismatch: expected %h, got %h", want.data, data_out_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          case (want.status)
            ST_OK:        ok_count_o++;
            ST_NOT_FOUND: missing_count_o++;
            ST_EMPTY:     empty_count_o++;
            default:      full_count_o++;
          endcase
        end
      end
      if (in_valid_i && !in_stall_i) begin
        owed_results.push_back(resolve_symbol_op(sst_cmd_e'(cmd_i), key_i, data_in_i));
        if (stack_fill > int'(peak_fill_o)) peak_fill_o = stack_fill;
      end
      owed_count_o = owed_results.size();
    end
  end

endmodule

// ===== tb/tb_scoped_symbol_stack_table.sv =====
// Top of the scoped symbol stack table testbench: clock, reset, stimulus words,
// output stall pattern and the final verdict. Depends on sst_pkg, the block
// and symbol_table_checker.
module tb_scoped_symbol_stack_table;
  import sst_pkg::*;

  // Phases of the random part; each leans the command mix one way so the
  // stack walks between empty and full instead of hovering in the middle.
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_e;
  // Output stall behaviors, each held for a random run before the next is drawn.
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_RUNS, STALL_TOGGLE} stall_mode_e;

  localparam int unsigned RANDOM_WORDS = 1130;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned SETTLE_CYCLES = 120;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [1:0]            cmd_i;
  logic [KEY_BITS-1:0]   key_i;
  logic [VALUE_BITS-1:0] data_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [VALUE_BITS-1:0] data_out_o;
  logic [1:0]            status_o;

  int unsigned fail_count;
  int unsigned owed_count;
  int unsigned words_checked;
  int unsigned ok_count;
  int unsigned missing_count;
  int unsigned empty_count;
  int unsigned full_count;
  int unsigned peak_fill;

  // sender pacing state
  int burst_left;
  // small key pool so gets and sets actually hit, and pushes shadow
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  scoped_symbol_stack_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .key_i       (key_i),
    .data_in_i   (data_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o)
  );

  symbol_table_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .cmd_i           (cmd_i),
    .key_i           (key_i),
    .data_in_i       (data_in_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_out_i      (data_out_o),
    .status_i        (status_o),
    .fail_count_o    (fail_count),
    .owed_count_o    (owed_count),
    .words_checked_o (words_checked),
    .ok_count_o      (ok_count),
    .missing_count_o (missing_count),
    .empty_count_o   (empty_count),
    .full_count_o    (full_count),
    .peak_fill_o     (peak_fill)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hang guard: ends the run as failed if it never finishes.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stall pattern independent of the sender.
  initial begin
    stall_mode_e mode;
    int          run;
    int          hold;
    logic        level;
    out_stall_i = 1'b0;
    hold  = 0;
    level = 1'b0;
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      run  = $urandom_range(20, 200);
      repeat (run) begin
        @(posedge clk_i);
        case (mode)
          STALL_NONE:   out_stall_i <= 1'b0;
          STALL_SPARSE: out_stall_i <= ($urandom_range(0, 3) == 0);
          STALL_RUNS: begin
            // alternating runs of stall and release of random length
            if (hold == 0) begin
              hold  = $urandom_range(1, 10);
              level = ~level;
            end
            hold--;
            out_stall_i <= level;
          end
          default:      out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  // Drop valid for a random gap at the end of a burst. A zero gap keeps valid
  // high, so back-to-back bursts happen too.
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Offer one word and hold it until accepted; called just after a rising edge.
  task automatic send_word(input sst_cmd_e op, input logic [KEY_BITS-1:0] k,
                           input logic [VALUE_BITS-1:0] v);
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    key_i      <= k;
    data_in_i  <= v;
    do @(posedge clk_i); while (in_stall_o);
    pace_sender();
  endtask

  // Hold off until every owed result has come back. The owed count is read
  // on the falling edge, away from the checker's updates.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed_count != 0);
    @(posedge clk_i);
  endtask

  function automatic sst_cmd_e pick_op(input phase_e ph);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 70) return CMD_PUSH;
        if (r < 85) return CMD_SET;
        return CMD_GET;
      end
      PH_DRAIN: begin
        if (r < 75) return CMD_POP;
        return CMD_GET;
      end
      default: begin
        if (r < 30) return CMD_GET;
        if (r < 55) return CMD_SET;
        if (r < 80) return CMD_PUSH;
        return CMD_POP;
      end
    endcase
  endfunction

  // Mostly pool keys; now and then a fresh key, or a pool slot is replaced so
  // old entries with retired keys pile up below the live ones.
  function automatic logic [KEY_BITS-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) key_pool[$urandom_range(0, POOL_SIZE - 1)] = KEY_BITS'($urandom());
    if (r < 82) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return KEY_BITS'($urandom());
  endfunction

  initial begin
    phase_e      ph;
    int          phase_len;
    int unsigned random_sent;
    int unsigned phase_count;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = CMD_GET;
    key_i       = '0;
    data_in_i   = '0;
    burst_left  = 1;
    random_sent = 0;
    phase_count = 0;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_BITS'($urandom());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-stack errors, key/value extremes, shadowing and unshadowing.
    send_word(CMD_POP,  16'h0000, 32'h0000_0000);  // pop on empty
    send_word(CMD_GET,  16'h0000, 32'h0000_0000);  // get on empty: not found
    send_word(CMD_SET,  16'hFFFF, 32'hFFFF_FFFF);  // set miss pushes
    send_word(CMD_PUSH, 16'h0000, 32'h0000_0000);
    send_word(CMD_GET,  16'hFFFF, 32'h0000_0000);
    send_word(CMD_GET,  16'h0000, 32'hFFFF_FFFF);  // data ignored by get
    send_word(CMD_SET,  16'h0000, 32'h1234_5678);  // overwrite newest match
    send_word(CMD_PUSH, 16'h0000, 32'hA5A5_A5A5);  // shadow key 0
    send_word(CMD_GET,  16'h0000, 32'h0000_0000);  // sees the shadowing entry
    send_word(CMD_SET,  16'h0000, 32'h5A5A_5A5A);  // hits the top copy only
    send_word(CMD_GET,  16'h5555, 32'h0000_0000);  // not found
    send_word(CMD_PUSH, 16'hAAAA, 32'h8000_0001);
    send_word(CMD_GET,  16'hFFFF, 32'h0000_0000);  // deepest entry
    send_word(CMD_POP,  16'hFFFF, 32'hFFFF_FFFF);  // key/data ignored by pop
    send_word(CMD_POP,  16'h0000, 32'h0000_0000);  // removes the shadow
    send_word(CMD_GET,  16'h0000, 32'h0000_0000);  // older copy visible again
    send_word(CMD_POP,  16'h0000, 32'h0000_0000);
    send_word(CMD_POP,  16'h0000, 32'h0000_0000);  // last entry
    send_word(CMD_POP,  16'h0000, 32'h0000_0000);  // empty again
    send_word(CMD_GET,  16'hFFFF, 32'h0000_0000);  // popped key is gone
    wait_results_drained();

    // Random phases. Fill phases run past capacity, so full refusals and set
    // hits on a full stack show up; drain phases run into the empty stack.
    while (random_sent < RANDOM_WORDS) begin
      ph        = phase_e'($urandom_range(0, 2));
      phase_len = (ph == PH_FILL) ? $urandom_range(80, 110) : $urandom_range(40, 90);
      // last phase stops at the word budget
      if (phase_len > int'(RANDOM_WORDS - random_sent)) begin
        phase_len = int'(RANDOM_WORDS - random_sent);
      end
      repeat (phase_len) begin
        send_word(pick_op(ph), pick_key(), $urandom());
        random_sent++;
      end
      phase_count++;
      // let the pipeline run dry now and then, always after the first phase
      if (phase_count == 1 || $urandom_range(0, 2) == 0) wait_results_drained();
    end

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run: %0d random words in %0d phases, %0d results checked",
             random_sent, phase_count, words_checked);
    $display("run: stack depth peaked at %0d; ok %0d, key missing %0d, empty pops %0d, full %0d",
             peak_fill, ok_count, missing_count, empty_count, full_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
